/* rtl/core/rgbxyz_pkg.sv */
package rgbxyz_pkg;

  localparam int unsigned InW      = 16;
  localparam int unsigned OutW     = 20;
  localparam int unsigned FracBits = 16;
  localparam int unsigned DetW     = 36;
  localparam int unsigned PeW      = 18;
  localparam int unsigned NumW     = 52;
  localparam int unsigned DenW     = 51;

  typedef struct packed {
    logic [InW-1:0] rx, ry, gx, gy, bx, by, wx, wy;
  } prim_t;

  // Magnitude / sign of one quotient job.
  typedef struct packed {
    logic [NumW-1:0] num;
    logic            neg;
  } job_t;

endpackage

/* rtl/core/rgbxyz_det.sv */
// Stage A: the four 3x3 determinants; all twelve 16x17 products are registered, then summed per determinant.
module rgbxyz_det (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  rgbxyz_pkg::prim_t                   prim_i,
  output logic                                vld_o,
  output rgbxyz_pkg::prim_t                   prim_o,
  output logic signed [rgbxyz_pkg::DetW-1:0]  t_o,
  output logic signed [rgbxyz_pkg::DetW-1:0]  ti_o [3]
);
  localparam int unsigned W = rgbxyz_pkg::DetW;

  logic signed [W-1:0] x [4][3];
  logic signed [W-1:0] y [4][3];
  logic signed [W-1:0] p_d [4][3];
  logic signed [W-1:0] p_q [4][3];
  logic signed [W-1:0] s_q [4];
  rgbxyz_pkg::prim_t prim1_q, prim2_q;
  logic vld1_q, vld2_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      x[k][0] = (k == 1) ? W'(prim_i.wx) : W'(prim_i.rx);
      y[k][0] = (k == 1) ? W'(prim_i.wy) : W'(prim_i.ry);
      x[k][1] = (k == 2) ? W'(prim_i.wx) : W'(prim_i.gx);
      y[k][1] = (k == 2) ? W'(prim_i.wy) : W'(prim_i.gy);
      x[k][2] = (k == 3) ? W'(prim_i.wx) : W'(prim_i.bx);
      y[k][2] = (k == 3) ? W'(prim_i.wy) : W'(prim_i.by);
      p_d[k][0] = x[k][0] * (y[k][1] - y[k][2]);
      p_d[k][1] = x[k][1] * (y[k][2] - y[k][0]);
      p_d[k][2] = x[k][2] * (y[k][0] - y[k][1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      prim1_q <= prim_i;
      prim2_q <= prim1_q;
      for (int k = 0; k < 4; k++) s_q[k] <= p_q[k][0] + p_q[k][1] + p_q[k][2];
    end
  end

  assign vld_o  = vld2_q;
  assign prim_o = prim2_q;
  assign t_o    = s_q[0];
  assign ti_o[0] = s_q[1];
  assign ti_o[1] = s_q[2];
  assign ti_o[2] = s_q[3];
endmodule

/* rtl/core/rgbxyz_jobs.sv */
// Stage B: nine numerator products, denominator, signs, degenerate flag.
module rgbxyz_jobs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  rgbxyz_pkg::prim_t                   prim_i,
  input  logic signed [rgbxyz_pkg::DetW-1:0]  t_i,
  input  logic signed [rgbxyz_pkg::DetW-1:0]  ti_i [3],
  output logic                                vld_o,
  output logic                                degen_o,
  output logic [rgbxyz_pkg::DenW-1:0]         den_o,
  output rgbxyz_pkg::job_t                    job_o [9]
);
  localparam int unsigned DW = rgbxyz_pkg::DetW;
  localparam int unsigned PW = rgbxyz_pkg::PeW;
  localparam int unsigned NW = rgbxyz_pkg::NumW;
  localparam int unsigned One = 1 << rgbxyz_pkg::InW;

  logic signed [PW-1:0] pe [3][3];
  logic [DW-1:0] tim [3];
  logic [DW-1:0] tm;
  logic [PW-1:0] pem [3][3];
  rgbxyz_pkg::job_t job_d [9];
  rgbxyz_pkg::job_t job_q [9];
  logic degen_d, degen_q, vld_q;
  logic [rgbxyz_pkg::DenW-1:0] den_q;
  logic [rgbxyz_pkg::InW-1:0] px [3], py [3];

  always_comb begin
    px[0] = prim_i.rx; py[0] = prim_i.ry;
    px[1] = prim_i.gx; py[1] = prim_i.gy;
    px[2] = prim_i.bx; py[2] = prim_i.by;
    tm = t_i[DW-1] ? DW'(-t_i) : DW'(t_i);
    for (int i = 0; i < 3; i++) begin
      tim[i] = ti_i[i][DW-1] ? DW'(-ti_i[i]) : DW'(ti_i[i]);
      pe[0][i] = PW'(px[i]);
      pe[1][i] = PW'(py[i]);
      pe[2][i] = PW'(One) - PW'(px[i]) - PW'(py[i]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        pem[r][i] = pe[r][i][PW-1] ? PW'(-pe[r][i]) : PW'(pe[r][i]);
        job_d[r*3+i].num = NW'(pem[r][i]) * NW'(tim[i]);
        job_d[r*3+i].neg = (pe[r][i][PW-1] ^ ti_i[i][DW-1]) ^ t_i[DW-1];
      end
    end
    degen_d = (py[0] == '0) || (py[1] == '0) || (py[2] == '0) ||
              (prim_i.wy == '0) || (t_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      job_q   <= job_d;
      degen_q <= degen_d;
      den_q   <= rgbxyz_pkg::DenW'(prim_i.wy) * rgbxyz_pkg::DenW'(tm);
    end
  end

  assign vld_o   = vld_q;
  assign degen_o = degen_q;
  assign den_o   = den_q;
  assign job_o   = job_q;
endmodule

/* rtl/core/rgbxyz_div.sv */
// Stage C: pipelined restoring divider, one quotient bit per stage,
// quotient limited to what saturation needs; then round and saturate.
module rgbxyz_div #(
  parameter int unsigned FRAC_BITS = rgbxyz_pkg::FracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic                               degen_i,
  input  logic [rgbxyz_pkg::DenW-1:0]        den_i,
  input  rgbxyz_pkg::job_t                   job_i [9],
  output logic                               vld_o,
  output logic                               degen_o,
  output logic signed [rgbxyz_pkg::OutW-1:0] m_o [9]
);
  localparam int unsigned OW = rgbxyz_pkg::OutW;
  localparam int unsigned DW = rgbxyz_pkg::DenW;
  localparam int unsigned NW = rgbxyz_pkg::NumW;
  localparam int unsigned QB = OW + 1;
  localparam int unsigned XW = NW + FRAC_BITS;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned Stg = QB + 1;
  localparam logic [QB:0] PosMax = (QB+1)'((1 << (OW-1)) - 1);
  localparam logic [QB:0] NegMax = (QB+1)'(1 << (OW-1));

  // Quotient of 2^QB or more saturates anyway: precheck x >= den << QB.
  logic [XW+QB-1:0] rem_q [Stg][9];
  logic [QB-1:0]    quo_q [Stg][9];
  logic             ovf_q [Stg][9];
  logic             neg_q [Stg][9];
  logic [DW-1:0]    den_q [Stg];
  logic             degen_q [Stg];
  logic             vld_q [Stg];
  logic signed [OW-1:0] m_q [9];
  logic             degen_out_q, vld_out_q;

  logic [XW+QB-1:0] dsh [QB];
  logic [XW+QB-1:0] x0 [9];
  logic [XW+QB-1:0] dtop;

  always_comb begin
    dtop = (XW+QB)'(den_i) << QB;
    for (int j = 0; j < 9; j++) x0[j] = (XW+QB)'(job_i[j].num) << FRAC_BITS;
    for (int s = 0; s < QB; s++)
      dsh[s] = (XW+QB)'(den_q[s]) << (QB - 1 - s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stg; s++) vld_q[s] <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int s = 1; s < Stg; s++) vld_q[s] <= vld_q[s-1];
      vld_out_q <= vld_q[Stg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]   <= den_i;
      degen_q[0] <= degen_i;
      for (int j = 0; j < 9; j++) begin
        rem_q[0][j] <= x0[j];
        quo_q[0][j] <= '0;
        ovf_q[0][j] <= (x0[j] >= dtop);
        neg_q[0][j] <= job_i[j].neg;
      end
      for (int s = 1; s < Stg; s++) begin
        den_q[s]   <= den_q[s-1];
        degen_q[s] <= degen_q[s-1];
        for (int j = 0; j < 9; j++) begin
          ovf_q[s][j] <= ovf_q[s-1][j];
          neg_q[s][j] <= neg_q[s-1][j];
          if (rem_q[s-1][j] >= dsh[s-1]) begin
            rem_q[s][j] <= rem_q[s-1][j] - dsh[s-1];
            quo_q[s][j] <= {quo_q[s-1][j][QB-2:0], 1'b1};
          end else begin
            rem_q[s][j] <= rem_q[s-1][j];
            quo_q[s][j] <= {quo_q[s-1][j][QB-2:0], 1'b0};
          end
        end
      end
      degen_out_q <= degen_q[Stg-1];
      for (int j = 0; j < 9; j++) begin : g_fin
        logic [QB:0] qr;
        logic [RW-1:0] r2;
        r2 = RW'(rem_q[Stg-1][j]) << 1;
        qr = {1'b0, quo_q[Stg-1][j]} +
             (QB+1)'(r2 >= RW'(den_q[Stg-1]));
        if (degen_q[Stg-1]) m_q[j] <= '0;
        else if (neg_q[Stg-1][j]) begin
          if (ovf_q[Stg-1][j] || qr > NegMax) m_q[j] <= OW'(-NegMax);
          else m_q[j] <= OW'(-qr);
        end else begin
          if (ovf_q[Stg-1][j] || qr > PosMax) m_q[j] <= OW'(PosMax);
          else m_q[j] <= OW'(qr);
        end
      end
    end
  end

  assign vld_o   = vld_out_q;
  assign degen_o = degen_out_q;
  assign m_o     = m_q;
endmodule

/* rtl/core/rgb_to_xyz_matrix_from_primaries.sv */
// RGB-to-XYZ matrix from primary and white chromaticities.
// Input beat (s_axis): eight unsigned Q0.16 chromaticities. Output beat
// (m_axis): nine signed 20-bit matrix entries plus the degenerate flag.
// One beat is accepted per cycle while the output is not stalled; the
// pipeline holds determinant registers, a product register, divider steps
// (an overflow precheck, then one quotient bit per stage, nine lanes) and
// a rounding register.
// Throughput is one matrix per cycle while m_axis does not stall.
// Reset clears all valid bits, so beats in flight are dropped.
// When m_axis_tready is low with a valid result waiting, the whole pipeline
// holds (a single global enable), so s_axis_tready drops too; a bubble at the
// output lets it advance again.
// Degenerate inputs (zero y or collinear primaries) give zeros and flag 1.
module rgb_to_xyz_matrix_from_primaries #(
  parameter int unsigned FRAC_BITS = rgbxyz_pkg::FracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // red_x, red_y, green_x, green_y, blue_x, blue_y, white_x, white_y
  input  logic [127:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate, zero fill
  output logic [183:0]  m_axis_tdata
);
  localparam int unsigned OW = rgbxyz_pkg::OutW;

  logic en;
  rgbxyz_pkg::prim_t prim, prim_a;
  logic vld_a, vld_b, vld_c, degen_b, degen_c;
  logic signed [rgbxyz_pkg::DetW-1:0] t_a;
  logic signed [rgbxyz_pkg::DetW-1:0] ti_a [3];
  logic [rgbxyz_pkg::DenW-1:0] den_b;
  rgbxyz_pkg::job_t job_b [9];
  logic signed [OW-1:0] m_c [9];

  assign en = m_axis_tready || !vld_c;
  assign s_axis_tready = en;

  assign prim.rx = s_axis_tdata[15:0];
  assign prim.ry = s_axis_tdata[31:16];
  assign prim.gx = s_axis_tdata[47:32];
  assign prim.gy = s_axis_tdata[63:48];
  assign prim.bx = s_axis_tdata[79:64];
  assign prim.by = s_axis_tdata[95:80];
  assign prim.wx = s_axis_tdata[111:96];
  assign prim.wy = s_axis_tdata[127:112];

  rgbxyz_det u_det (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid), .prim_i(prim),
    .vld_o(vld_a), .prim_o(prim_a), .t_o(t_a), .ti_o(ti_a)
  );

  rgbxyz_jobs u_jobs (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld_a), .prim_i(prim_a), .t_i(t_a),
    .ti_i(ti_a), .vld_o(vld_b), .degen_o(degen_b), .den_o(den_b), .job_o(job_b)
  );

  rgbxyz_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld_b), .degen_i(degen_b),
    .den_i(den_b), .job_i(job_b), .vld_o(vld_c), .degen_o(degen_c), .m_o(m_c)
  );

  assign m_axis_tvalid = vld_c;
  always_comb begin
    m_axis_tdata = '0;
    for (int j = 0; j < 9; j++) m_axis_tdata[j*OW +: OW] = m_c[j];
    m_axis_tdata[9*OW] = degen_c;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("not ready with empty output");
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && degen_c |-> m_axis_tdata[9*OW-1:0] == '0)
    else $error("degenerate result not zero");
endmodule
